// ===== src/srbo_pkg.sv =====
// srbo_pkg: shared types and constants of the sample ring buffer
// used by the channel interfaces, the remainder unit and the top level
`default_nettype none

package srbo_pkg;

  localparam int DEPTH_DEFAULT = 32;   // ring entries in the store
  localparam int CAP_W         = 6;    // width of the capacity register
  localparam int CAP_RESET     = 32;   // capacity after reset
  localparam int FRAME_W       = 24;   // raw three-byte sensor frame
  localparam int SAMPLE_W      = 18;   // unpacked sample
  localparam int STEP_W        = $clog2(CAP_W);

  typedef enum logic {
    OP_PUSH    = 1'b0,
    OP_ADVANCE = 1'b1
  } srbo_op_e;

  typedef struct packed {
    logic busy;
    logic done;
  } srbo_rem_stat_t;

endpackage

`default_nettype wire

// ===== src/srbo_item_if.sv =====
// srbo_item_if: input channel of the ring buffer, one push or advance per beat
// depends on srbo_pkg
`default_nettype none

interface srbo_item_if;
  logic                             valid;
  logic                             ready;
  srbo_pkg::srbo_op_e               operation;
  logic [srbo_pkg::FRAME_W-1:0]     ir_bytes;
  logic [srbo_pkg::FRAME_W-1:0]     red_bytes;

  modport source (output valid, operation, ir_bytes, red_bytes, input ready);
  modport sink   (input valid, operation, ir_bytes, red_bytes, output ready);
endinterface

`default_nettype wire

// ===== src/srbo_result_if.sv =====
// srbo_result_if: result channel, oldest sample pair and status flags per beat
// depends on srbo_pkg
`default_nettype none

interface srbo_result_if;
  logic                             valid;
  logic                             ready;
  logic [srbo_pkg::SAMPLE_W-1:0]    oldest_ir;
  logic [srbo_pkg::SAMPLE_W-1:0]    oldest_red;
  logic                             available;
  logic                             is_full;

  modport source (output valid, oldest_ir, oldest_red, available, is_full, input ready);
  modport sink   (input valid, oldest_ir, oldest_red, available, is_full, output ready);
endinterface

`default_nettype wire

// ===== src/srbo_cfg_if.sv =====
// srbo_cfg_if: capacity register write channel
// depends on srbo_pkg
`default_nettype none

interface srbo_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [srbo_pkg::CAP_W-1:0]     data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== src/srbo_rem.sv =====
// srbo_rem: two-lane restoring remainder unit, one quotient bit per cycle
// recomputes the wrap points after a capacity write; depends on srbo_pkg
`default_nettype none

module srbo_rem (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start_i,
  input  wire [srbo_pkg::CAP_W-1:0]   num_a_i,
  input  wire [srbo_pkg::CAP_W-1:0]   num_b_i,
  input  wire [srbo_pkg::CAP_W-1:0]   den_i,
  output logic [srbo_pkg::CAP_W-1:0]  rem_a_o,
  output logic [srbo_pkg::CAP_W-1:0]  rem_b_o,
  output srbo_pkg::srbo_rem_stat_t    stat_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [srbo_pkg::STEP_W-1:0]   cnt_q, cnt_d;
  logic [srbo_pkg::CAP_W-1:0]    den_q, den_d;
  logic [srbo_pkg::CAP_W-1:0]    na_q, na_d, nb_q, nb_d;
  logic [srbo_pkg::CAP_W-1:0]    ra_q, ra_d, rb_q, rb_d;

  function automatic logic [srbo_pkg::CAP_W-1:0] rem_step(
    input logic [srbo_pkg::CAP_W-1:0] r,
    input logic                       b,
    input logic [srbo_pkg::CAP_W-1:0] d
  );
    logic [srbo_pkg::CAP_W:0] s;
    s = {r, b};
    if (s >= {1'b0, d}) begin
      s = s - {1'b0, d};
    end
    return s[srbo_pkg::CAP_W-1:0];
  endfunction

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    den_d  = den_q;
    na_d   = na_q;
    nb_d   = nb_q;
    ra_d   = ra_q;
    rb_d   = rb_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = srbo_pkg::STEP_W'(srbo_pkg::CAP_W - 1);
      den_d  = den_i;
      na_d   = num_a_i;
      nb_d   = num_b_i;
      ra_d   = '0;
      rb_d   = '0;
    end else if (busy_q) begin
      // msb first through the dividend
      ra_d = rem_step(ra_q, na_q[cnt_q], den_q);
      rb_d = rem_step(rb_q, nb_q[cnt_q], den_q);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    na_q  <= na_d;
    nb_q  <= nb_d;
    ra_q  <= ra_d;
    rb_q  <= rb_d;
  end

  assign rem_a_o     = ra_q;
  assign rem_b_o     = rb_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

`ifndef NO_ASSERTIONS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("remainder done without a preceding busy cycle");

  a_not_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && done_q))
    else $error("remainder busy and done together");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (ra_q < den_q) && (rb_q < den_q))
    else $error("remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ===== src/sample_ring_buffer_overwrite.sv =====
// sample_ring_buffer_overwrite: top level of the paired ir/red sample ring
// depends on srbo_pkg, srbo_item_if, srbo_result_if, srbo_cfg_if, srbo_rem
`default_nettype none

// Ring buffer of paired infrared/red samples that drops the oldest pair when
// full. Each input beat (push or advance) yields one result beat in the
// following cycle, carrying the pair at the tail and the status flags; one
// item per cycle is sustained while the skid register is empty and no capacity
// write is being folded in, set by the store with one write and one registered
// read per cycle. A result register plus a skid register let one more item in
// while a result waits. A capacity write stalls intake while the remainder unit
// folds the head and tail wrap points into the new capacity. The store reads as
// zero after reset through per-entry valid bits, so there is no clearing pass.
// Capacity 0 acts as 1, above min(DEPTH, 63) as min(DEPTH, 63).
module sample_ring_buffer_overwrite #(
  parameter int DEPTH = srbo_pkg::DEPTH_DEFAULT
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  srbo_item_if.sink       item_i,
  srbo_cfg_if.sink        cfg_i,
  srbo_result_if.source   result_o
);

  localparam int MAX_CAP = (DEPTH < 63) ? DEPTH : 63;
  localparam int PTR_W   = (MAX_CAP > 1) ? $clog2(MAX_CAP) : 1;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CAP_RST_EFF =
    (srbo_pkg::CAP_RESET > MAX_CAP) ? MAX_CAP : srbo_pkg::CAP_RESET;
  localparam int NEXT_RST = (CAP_RST_EFF > 1) ? 1 : 0;

  localparam int CW = srbo_pkg::CAP_W;
  localparam int SW = srbo_pkg::SAMPLE_W;

  // pointer state, with the precomputed next position of each pointer
  logic [PTR_W-1:0]  head_q, head_d, head_nx_q, head_nx_d;
  logic [PTR_W-1:0]  tail_q, tail_d, tail_nx_q, tail_nx_d;
  logic              full_q, full_d;
  logic [CW-1:0]     cap_q, cap_d;

  // store
  logic [SW-1:0]     ir_mem_q  [DEPTH];
  logic [SW-1:0]     red_mem_q [DEPTH];
  logic [DEPTH-1:0]  vld_q;

  // result stage and skid
  logic              s1_valid_q, s1_valid_d;
  logic              skid_valid_q, skid_valid_d;
  logic [SW-1:0]     rd_ir_q, rd_red_q, wr_ir_q, wr_red_q;
  logic              rd_vld_q, byp_q, avail_q, isfull_q;
  logic [SW-1:0]     s1_ir, s1_red;
  logic [SW-1:0]     skid_ir_q, skid_red_q;
  logic              skid_avail_q, skid_full_q;

  logic              item_accept, cfg_accept, is_push, push_wr;
  logic [SW-1:0]     new_ir, new_red;
  logic [CW-1:0]     cfg_cap;
  logic [CW-1:0]     rem_a, rem_b;
  srbo_pkg::srbo_rem_stat_t rem_stat;

  function automatic logic [PTR_W-1:0] inc_wrap(
    input logic [PTR_W-1:0] p,
    input logic [CW-1:0]    cap
  );
    logic [CW-1:0] s;
    s = CW'(p) + 1'b1;
    return (s == cap) ? '0 : PTR_W'(s);
  endfunction

  // the low two bits of the first byte sit right above the other two bytes
  function automatic logic [SW-1:0] unpack(input logic [srbo_pkg::FRAME_W-1:0] f);
    return f[SW-1:0];
  endfunction

  assign cfg_i.ready = 1'b1;
  assign cfg_accept  = cfg_i.valid && cfg_i.ready;

  always_comb begin
    cfg_cap = cfg_i.data;
    if (cfg_cap == '0) begin
      cfg_cap = CW'(1);
    end else if (int'(cfg_cap) > MAX_CAP) begin
      cfg_cap = CW'(MAX_CAP);
    end
  end

  srbo_rem u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_accept),
    .num_a_i (CW'(head_q) + 1'b1),
    .num_b_i (CW'(tail_q) + 1'b1),
    .den_i   (cfg_cap),
    .rem_a_o (rem_a),
    .rem_b_o (rem_b),
    .stat_o  (rem_stat)
  );

  assign item_i.ready = !skid_valid_q && !rem_stat.busy && !rem_stat.done;
  assign item_accept  = item_i.valid && item_i.ready;
  assign is_push      = (item_i.operation == srbo_pkg::OP_PUSH);
  assign push_wr      = item_accept && is_push;
  assign new_ir       = unpack(item_i.ir_bytes);
  assign new_red      = unpack(item_i.red_bytes);

  always_comb begin
    head_d    = head_q;
    head_nx_d = head_nx_q;
    tail_d    = tail_q;
    tail_nx_d = tail_nx_q;
    full_d    = full_q;
    cap_d     = cap_q;
    if (cfg_accept) begin
      cap_d = cfg_cap;
    end
    if (rem_stat.done) begin
      head_nx_d = PTR_W'(rem_a);
      tail_nx_d = PTR_W'(rem_b);
    end
    if (item_accept) begin
      unique case (item_i.operation)
        srbo_pkg::OP_PUSH: begin
          head_d    = head_nx_q;
          head_nx_d = inc_wrap(head_nx_q, cap_q);
          if (full_q) begin
            tail_d    = tail_nx_q;
            tail_nx_d = inc_wrap(tail_nx_q, cap_q);
          end else if (head_nx_q == tail_q) begin
            full_d = 1'b1;
          end
        end
        srbo_pkg::OP_ADVANCE: begin
          if (!(head_q == tail_q && !full_q)) begin
            tail_d    = tail_nx_q;
            tail_nx_d = inc_wrap(tail_nx_q, cap_q);
            full_d    = 1'b0;
          end
        end
        default: begin
          head_d = head_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      head_nx_q <= PTR_W'(NEXT_RST);
      tail_nx_q <= PTR_W'(NEXT_RST);
      full_q    <= 1'b0;
      cap_q     <= CW'(CAP_RST_EFF);
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      head_nx_q <= head_nx_d;
      tail_nx_q <= tail_nx_d;
      full_q    <= full_d;
      cap_q     <= cap_d;
    end
  end

  // store write and registered read at the new tail
  always_ff @(posedge clk_i) begin
    if (push_wr) begin
      ir_mem_q[ADDR_W'(head_q)]  <= new_ir;
      red_mem_q[ADDR_W'(head_q)] <= new_red;
    end
    if (item_accept) begin
      rd_ir_q  <= ir_mem_q[ADDR_W'(tail_d)];
      rd_red_q <= red_mem_q[ADDR_W'(tail_d)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (push_wr) begin
      vld_q[ADDR_W'(head_q)] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_accept) begin
      rd_vld_q <= vld_q[ADDR_W'(tail_d)];
      byp_q    <= is_push && (head_q == tail_d);   // tail lands on the entry just written
      wr_ir_q  <= new_ir;
      wr_red_q <= new_red;
      avail_q  <= !(head_d == tail_d && !full_d);
      isfull_q <= full_d;
    end
  end

  assign s1_ir  = byp_q ? wr_ir_q  : (rd_vld_q ? rd_ir_q  : '0);
  assign s1_red = byp_q ? wr_red_q : (rd_vld_q ? rd_red_q : '0);

  always_comb begin
    s1_valid_d   = s1_valid_q;
    skid_valid_d = skid_valid_q;
    if (item_accept) begin
      s1_valid_d = 1'b1;
      if (s1_valid_q && !result_o.ready) begin
        skid_valid_d = 1'b1;
      end
    end else if (result_o.ready) begin
      if (skid_valid_q) begin
        skid_valid_d = 1'b0;
      end else begin
        s1_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      s1_valid_q   <= s1_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // older result parks here when a new one overwrites the result register
  always_ff @(posedge clk_i) begin
    if (item_accept && s1_valid_q && !result_o.ready) begin
      skid_ir_q    <= s1_ir;
      skid_red_q   <= s1_red;
      skid_avail_q <= avail_q;
      skid_full_q  <= isfull_q;
    end
  end

  assign result_o.valid      = s1_valid_q || skid_valid_q;
  assign result_o.oldest_ir  = skid_valid_q ? skid_ir_q    : s1_ir;
  assign result_o.oldest_red = skid_valid_q ? skid_red_q   : s1_red;
  assign result_o.available  = skid_valid_q ? skid_avail_q : avail_q;
  assign result_o.is_full    = skid_valid_q ? skid_full_q  : isfull_q;

`ifndef NO_ASSERTIONS
  a_full_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> (head_q == tail_q))
    else $error("full flag set with head and tail apart");

  a_no_item_while_recalc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_stat.busy |-> !item_accept)
    else $error("item taken while wrap points are recomputed");

  a_skid_behind_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> s1_valid_q)
    else $error("skid holds a result with the result register empty");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_accept |=> s1_valid_q)
    else $error("accepted item left no result");
`endif

endmodule

`default_nettype wire
